[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, reset on i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ST_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[src/st_pkg.sv]
// ----------------------------------------------------------------------------
// st_pkg
// Widths, term-cell data bundle and reciprocal table for the sine series.
// ----------------------------------------------------------------------------
`default_nettype none
package st_pkg;
    localparam int ST_ANGLE_W = 31;
    localparam int ST_OUT_W   = 32;
    localparam int ST_CFG_W   = 4;
    localparam int ST_N_W     = 5;
    localparam int ST_MAG_W   = 31;
    localparam int ST_T_W     = 34;
    localparam int ST_X2_W    = 33;
    localparam int ST_Q_W     = 32;
    localparam int ST_SUM_W   = 40;
    localparam int ST_RCP_W   = 30;
    localparam int ST_MAX_TERMS_DEF = 12;
    localparam int ST_FRAC_BITS_DEF = 28;
    localparam logic [ST_CFG_W-1:0] ST_TERM_RESET = 4'd3;

    typedef struct packed {
        logic                       valid;
        logic                       neg;
        logic [ST_N_W-1:0]          n;
        logic [ST_T_W-1:0]          t;
        logic [ST_X2_W-1:0]         x2;
        logic signed [ST_SUM_W-1:0] sum;
    } t_pass;

    // round(2^32 / ((2j)(2j+1)))
    function automatic logic [ST_RCP_W-1:0] st_recip(input int j);
        logic [ST_RCP_W-1:0] r;
        case (j)
            1:       r = 30'd715827883;
            2:       r = 30'd214748365;
            3:       r = 30'd102261126;
            4:       r = 30'd59652324;
            5:       r = 30'd39045157;
            6:       r = 30'd27531842;
            7:       r = 30'd20452225;
            8:       r = 30'd15790321;
            9:       r = 30'd12558384;
            10:      r = 30'd10226113;
            11:      r = 30'd8488078;
            12:      r = 30'd7158279;
            13:      r = 30'd6118187;
            14:      r = 30'd5289369;
            15:      r = 30'd4618244;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[src/st_if.sv]
// ----------------------------------------------------------------------------
// st_if
// Valid/ready channels for angle, sine and configuration items.
// ----------------------------------------------------------------------------
`default_nettype none
interface st_angle_if import st_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [ST_ANGLE_W-1:0] angle;
    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface st_sine_if import st_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [ST_OUT_W-1:0] sine_value;
    modport source (output valid, output sine_value, input ready);
    modport sink   (input valid, input sine_value, output ready);
endinterface

interface st_cfg_if import st_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ST_CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/sine_taylor_series_top.sv]
// ----------------------------------------------------------------------------
// sine_taylor_series_top
// Truncated Taylor series of sin(x) on a Q3.28 angle, row of term cells.
// ----------------------------------------------------------------------------
// Channels: i_angle takes one angle item, o_sine returns one sine item per
// angle, i_cfg writes term_count (always ready; write only while idle).
// The angle is squared up front, then passes a row of MAX_TERMS-1 term
// cells, each with two registered multiplies, then output saturation.
// One item is in flight at a time: i_angle.ready drops on accept and returns
// the cycle after the result is taken. A stalled receiver holds the result in
// the output register and keeps new angles out.
// Reset clears the flight and output flags and sets term_count to 3.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sine_taylor_series_top import st_pkg::*; #(
    parameter int MAX_TERMS = ST_MAX_TERMS_DEF,
    parameter int FRAC_BITS = ST_FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    st_angle_if.sink    i_angle,
    st_cfg_if.sink      i_cfg,
    st_sine_if.source   o_sine
);
    localparam logic [61:0] HALF0 = 62'(1) << (FRAC_BITS - 1);
    localparam logic [61:0] X2LIM = 62'(1) << 32;
    localparam logic signed [ST_SUM_W-1:0] SMAX = ST_SUM_W'(64'sd2147483647);
    localparam logic signed [ST_SUM_W-1:0] SMIN = -ST_SUM_W'(64'sd2147483648);

    logic [ST_CFG_W-1:0]        r_term_count;
    logic                       r_busy, r_a_valid, r_b_valid, r_out_valid;
    logic [ST_MAG_W-1:0]        r_mag, r_b_mag;
    logic                       r_neg, r_b_neg;
    logic [ST_N_W-1:0]          r_n, r_b_n, n_n;
    logic [61:0]                r_sq, rnd0;
    logic signed [ST_OUT_W-1:0] r_out;
    logic [31:0]                mag_w;
    logic                       in_acc, out_acc;
    t_pass                      chain [MAX_TERMS];
    t_pass                      r_front;
    t_pass                      last;

    assign i_cfg.ready   = 1'b1;
    assign i_angle.ready = !r_busy;
    assign in_acc  = i_angle.valid && i_angle.ready;
    assign out_acc = o_sine.valid && o_sine.ready;

    always_comb begin
        mag_w = i_angle.angle[ST_ANGLE_W-1]
              ? 32'h8000_0000 - {1'b0, i_angle.angle}
              : {1'b0, i_angle.angle};
        if (r_term_count == '0)
            n_n = ST_N_W'(1);
        else if ({1'b0, r_term_count} > ST_N_W'(MAX_TERMS))
            n_n = ST_N_W'(MAX_TERMS);
        else
            n_n = {1'b0, r_term_count};
        rnd0 = (r_sq + HALF0) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count  <= ST_TERM_RESET;
            r_busy        <= 1'b0;
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_front.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                r_term_count <= i_cfg.data;
            r_a_valid     <= in_acc;
            r_b_valid     <= r_a_valid;
            r_front.valid <= r_b_valid;
            if (in_acc)
                r_busy <= 1'b1;
            else if (out_acc)
                r_busy <= 1'b0;
            if (last.valid)
                r_out_valid <= 1'b1;
            else if (out_acc)
                r_out_valid <= 1'b0;
        end
        if (in_acc) begin
            r_mag <= mag_w[ST_MAG_W-1:0];
            r_neg <= i_angle.angle[ST_ANGLE_W-1];
            r_n   <= n_n;
        end
        r_sq    <= 62'(r_mag) * 62'(r_mag);
        r_b_mag <= r_mag;
        r_b_neg <= r_neg;
        r_b_n   <= r_n;
        r_front.neg <= r_b_neg;
        r_front.n   <= r_b_n;
        r_front.t   <= ST_T_W'(r_b_mag);
        r_front.x2  <= (rnd0 > X2LIM) ? X2LIM[ST_X2_W-1:0] : rnd0[ST_X2_W-1:0];
        r_front.sum <= r_b_neg ? -$signed(ST_SUM_W'(r_b_mag))
                               : $signed(ST_SUM_W'(r_b_mag));
        if (last.valid) begin
            if (last.sum > SMAX)
                r_out <= SMAX[ST_OUT_W-1:0];
            else if (last.sum < SMIN)
                r_out <= SMIN[ST_OUT_W-1:0];
            else
                r_out <= last.sum[ST_OUT_W-1:0];
        end
    end

    assign chain[0] = r_front;

    genvar k;
    generate
        for (k = 1; k < MAX_TERMS; k++) begin : g_cell
            st_cell #(.J(k), .FRAC_BITS(FRAC_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_pass (chain[k-1]),
                .o_pass (chain[k])
            );
        end
    endgenerate

    assign last              = chain[MAX_TERMS-1];
    assign o_sine.valid      = r_out_valid;
    assign o_sine.sine_value = r_out;

    `ST_ASSERT(a_acc_busy, in_acc |=> !i_angle.ready, "accepted item did not block input")
    `ST_NEVER(a_out_idle, r_out_valid && !r_busy, "result shown with no item in flight")
    `ST_NEVER(a_end_idle, last.valid && !r_busy, "row finished an item never accepted")
    `ST_NEVER(a_end_dup, last.valid && r_out_valid, "second result while one waits")
endmodule
`default_nettype wire

[src/st_cell.sv]
// ----------------------------------------------------------------------------
// st_cell
// One term: t' = round(round(t*recip/2^32)*x2/2^F); sum gains or loses t'.
// ----------------------------------------------------------------------------
`default_nettype none
module st_cell import st_pkg::*; #(
    parameter int J         = 1,
    parameter int FRAC_BITS = ST_FRAC_BITS_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_pass i_pass,
    output t_pass o_pass
);
    localparam logic [ST_RCP_W-1:0] RECIP = st_recip(J);
    localparam logic [63:0] HALF1 = 64'(1) << 31;
    localparam logic [64:0] HALF2 = 65'(1) << (FRAC_BITS - 1);
    localparam logic [64:0] TLIM  = 65'(1) << 33;
    localparam logic        ODD   = 1'(J % 2);

    t_pass             r_s1, r_s2;
    logic [ST_Q_W-1:0] r_q;
    logic [63:0]       p1;
    logic [64:0]       p2, rnd;
    logic [ST_T_W-1:0] tn;
    logic              active, minus;
    t_pass             n_s2;

    assign p1 = 64'(i_pass.t) * 64'(RECIP) + HALF1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1.valid <= i_pass.valid;
            r_s2.valid <= n_s2.valid;
        end
        r_s1.neg <= i_pass.neg;
        r_s1.n   <= i_pass.n;
        r_s1.t   <= i_pass.t;
        r_s1.x2  <= i_pass.x2;
        r_s1.sum <= i_pass.sum;
        r_q      <= p1[63:32];
        r_s2.neg <= n_s2.neg;
        r_s2.n   <= n_s2.n;
        r_s2.t   <= n_s2.t;
        r_s2.x2  <= n_s2.x2;
        r_s2.sum <= n_s2.sum;
    end

    always_comb begin
        p2     = 65'(r_q) * 65'(r_s1.x2);
        rnd    = (p2 + HALF2) >> FRAC_BITS;
        tn     = (rnd > TLIM) ? TLIM[ST_T_W-1:0] : rnd[ST_T_W-1:0];
        active = (ST_N_W'(J) < r_s1.n);
        minus  = ODD ^ r_s1.neg;
        n_s2   = r_s1;
        if (active) begin
            n_s2.t   = tn;
            n_s2.sum = minus ? r_s1.sum - $signed({6'd0, tn})
                             : r_s1.sum + $signed({6'd0, tn});
        end
    end

    assign o_pass = r_s2;
endmodule
`default_nettype wire

[dv/tb_sine_taylor_series_top.sv]
// ----------------------------------------------------------------------------
// tb_sine_taylor_series_top
// Self-checking bench for the sine Taylor series block: angle items are
// driven in random bursts, results are checked against a bit-exact predictor
// across several term counts, with random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sine_taylor_series_top;
    import st_pkg::*;

    localparam int ANGLE_MAX  = 843314856;
    localparam int WDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    st_angle_if angle_ch ();
    st_sine_if  sine_ch ();
    st_cfg_if   cfg_ch ();

    sine_taylor_series_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_angle (angle_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_sine  (sine_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [3:0]            term_setting = ST_TERM_RESET;
    logic signed [30:0]    angle_queue[$];
    logic signed [31:0]    sine_expected[$];
    int                    err_count = 0;
    int                    checked = 0;
    int                    watchdog = 0;
    int                    burst_left = 0;
    int                    gap_left = 0;
    int                    stall_phase = 0;
    bit                    stall_on = 1'b1;
    bit                    timed_out = 1'b0;
    bit                    angle_taken = 1'b0;

    function automatic logic signed [31:0] sine_series(logic [30:0] raw, logic [3:0] cnt);
        logic        neg;
        logic [63:0] mag, x2, t, q, d, rcp;
        logic signed [63:0] acc;
        int          n;
        neg = raw[30];
        mag = neg ? (64'h8000_0000 - {33'd0, raw}) : {33'd0, raw};
        n = (cnt == 0) ? 1 : ((cnt > 12) ? 12 : int'(cnt));
        x2 = (mag * mag + (64'd1 << 27)) >> 28;
        if (x2 > (64'd1 << 32)) x2 = 64'd1 << 32;
        t = mag;
        acc = neg ? -$signed(t) : $signed(t);
        for (int j = 1; j < n; j++) begin
            d = 64'(2 * j) * 64'(2 * j + 1);
            rcp = ((64'd1 << 32) + d / 2) / d;
            q = (t * rcp + (64'd1 << 31)) >> 32;
            t = (q * x2 + (64'd1 << 27)) >> 28;
            if (t > (64'd1 << 33)) t = 64'd1 << 33;
            acc = (((j % 2) == 1) != neg) ? acc - $signed(t) : acc + $signed(t);
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // driver: bursts with gaps; hold only while the item is not yet taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            angle_ch.valid <= 1'b0;
        end else if (angle_ch.valid && !angle_taken) begin
            // hold item
        end else if (angle_queue.size() > 0 && gap_left == 0) begin
            angle_ch.valid <= 1'b1;
            angle_ch.angle <= angle_queue.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0
                : $urandom_range(1, 40);
        end else begin
            angle_ch.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end
    end

    // receiver stall pattern: random windows, some all-ready
    always @(negedge i_clk) begin
        if (stall_phase == 0) begin
            stall_on = ($urandom_range(0, 3) != 0);
            stall_phase = $urandom_range(5, 60);
        end
        stall_phase--;
        sine_ch.ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // monitor
    always @(posedge i_clk) begin
        angle_taken <= angle_ch.valid && angle_ch.ready;
        if (i_rst_n) begin
            if ((angle_ch.valid && angle_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (sine_ch.valid && sine_ch.ready))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (angle_ch.valid && angle_ch.ready) begin
                sine_expected.push_back(sine_series(angle_ch.angle[30:0], term_setting));
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                term_setting <= cfg_ch.data;
            end
            if (sine_ch.valid && sine_ch.ready) begin
                checked <= checked + 1;
                if (sine_expected.size() == 0) begin
                    report_mismatch("unexpected sine item", sine_ch.sine_value, 32'h0);
                end else if (sine_ch.sine_value !== sine_expected[0]) begin
                    report_mismatch("sine_value", sine_ch.sine_value, sine_expected[0]);
                    void'(sine_expected.pop_front());
                end else begin
                    void'(sine_expected.pop_front());
                end
            end
            if (watchdog >= WDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    task automatic write_terms(logic [3:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_all();
        while ((angle_queue.size() > 0 || angle_ch.valid || sine_expected.size() > 0)
               && !timed_out) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [30:0] pick_angle();
        case ($urandom_range(0, 5))
            0:       return 31'(ANGLE_MAX - $urandom_range(0, 255));
            1:       return 31'(-ANGLE_MAX + $urandom_range(0, 255));
            2:       return 31'($signed($urandom_range(0, 1023)) - 512);
            3:       return 31'($urandom);   // full range incl. beyond pi
            default: return 31'($signed($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        endcase
    endfunction

    initial begin
        logic [3:0] plan[7];
        plan = '{4'd3, 4'd1, 4'd12, 4'd0, 4'd15, 4'd6, 4'd13};
        angle_ch.valid = 1'b0;
        angle_ch.angle = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        sine_ch.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes at reset term count
        angle_queue = '{31'sd0, 31'(ANGLE_MAX), 31'(-ANGLE_MAX), 31'sd1, -31'sd1,
                        31'h3FFF_FFFF, 31'h4000_0000, 31'sd268435456, -31'sd268435456,
                        31'sd421657428};
        drain_all();
        for (int p = 0; p < 7 && !timed_out; p++) begin
            write_terms(plan[p]);
            for (int k = 0; k < 220; k++) angle_queue.push_back(pick_angle());
            drain_all();
        end

        $display("covered %0d sine items over term counts 3,1,12,0,15,6,13", checked);
        $display("angles spanned both pi limits, small values and the full 31-bit range");
        if (timed_out) begin
            $display("[FAIL] regression broken");
        end else if (err_count == 0 && sine_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+src
src/st_pkg.sv
src/st_if.sv
src/st_cell.sv
src/sine_taylor_series_top.sv
dv/tb_sine_taylor_series_top.sv
